@@ rtl/ltdc_pkg.sv @@
// ----------------------------------------------------------------------------
// ltdc_pkg
// Shared types, register indexes, state codes and a saturation helper for the
// line tracer drive control core.
// ----------------------------------------------------------------------------
`default_nettype none

package ltdc_pkg;

    localparam int MODE_COUNT_DEF = 4;
    localparam int HALF_TREAD_DEF = 45;
    localparam int NUM_TARGETS    = 4;
    localparam int TREAD_W        = 8;
    localparam int DIV_STEPS      = 32;
    localparam int STEP_W         = $clog2(DIV_STEPS);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET3    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_DELAY = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_LIMIT = 3'd7;

    localparam logic [15:0] FULL_SCALE_RST = 16'd1000;
    localparam logic [15:0] STOP_DELAY_RST = 16'd600;
    localparam logic [7:0]  GOAL_LIMIT_RST = 8'd2;

    localparam logic [1:0] ST_STOP    = 2'd0;
    localparam logic [1:0] ST_TO_RUN  = 2'd1;
    localparam logic [1:0] ST_RUN     = 2'd2;
    localparam logic [1:0] ST_TO_STOP = 2'd3;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic load;
        logic mul;
        logic div_step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic func;
        logic out_free;
    } t_dp_status;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] res;
        if (v > 34'(S32_MAX)) begin
            res = S32_MAX;
        end else if (v < 34'(S32_MIN)) begin
            res = S32_MIN;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ltdc_ctrl.sv @@
// ----------------------------------------------------------------------------
// ltdc_ctrl
// Sequencer: accept an item, multiply, run the serial divider (control ticks only), commit.
// ----------------------------------------------------------------------------
`default_nettype none

module ltdc_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  ltdc_pkg::t_dp_status i_status,
    output ltdc_pkg::t_dp_cmd   o_cmd
);

    localparam logic [1:0] SQ_IDLE = 2'd0;
    localparam logic [1:0] SQ_MUL  = 2'd1;
    localparam logic [1:0] SQ_DIV  = 2'd2;
    localparam logic [1:0] SQ_FIN  = 2'd3;

    logic [1:0]                    r_state, n_state;
    logic [ltdc_pkg::STEP_W-1:0]   r_step, n_step;
    logic                          w_accept;

    assign o_stall  = (r_state != SQ_IDLE);
    assign w_accept = i_valid && (r_state == SQ_IDLE);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            SQ_IDLE: begin
                o_cmd.load = w_accept;
                if (w_accept) begin
                    n_state = SQ_MUL;
                end
            end
            SQ_MUL: begin
                o_cmd.mul = 1'b1;
                n_step    = '0;
                n_state   = i_status.func ? SQ_FIN : SQ_DIV;
            end
            SQ_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == ltdc_pkg::STEP_W'(ltdc_pkg::DIV_STEPS - 1)) begin
                    n_state = SQ_FIN;
                end
            end
            SQ_FIN: begin
                o_cmd.commit = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = SQ_IDLE;
                end
            end
            default: begin
                n_state = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SQ_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SQ_IDLE && i_valid) |=> (r_state == SQ_MUL))
        else $error("accepted item did not start");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SQ_DIV && r_step == ltdc_pkg::STEP_W'(ltdc_pkg::DIV_STEPS - 1))
        |=> (r_state == SQ_FIN))
        else $error("divider did not finish after full step count");

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (i_status.out_free && r_state == SQ_FIN))
        else $error("commit while output register busy");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command");

endmodule

`default_nettype wire

@@ rtl/ltdc_dp.sv @@
// ----------------------------------------------------------------------------
// ltdc_dp
// Datapath: config registers, duty multiply and serial divide, differential
// drive with saturation, drive state and stop countdown, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ltdc_dp #(
    parameter int MODE_COUNT = ltdc_pkg::MODE_COUNT_DEF,
    parameter int HALF_TREAD = ltdc_pkg::HALF_TREAD_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [ltdc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [ltdc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire                                 i_func,
    input  wire  signed [15:0]                  i_line_offset,
    input  wire  [7:0]                          i_marker_count,
    input  wire  [15:0]                         i_battery_mv,
    input  wire  [1:0]                          i_new_state,
    input  ltdc_pkg::t_dp_cmd                   i_cmd,
    output ltdc_pkg::t_dp_status                o_status,
    input  wire                                 i_stall,
    output logic                                o_valid,
    output logic signed [31:0]                  o_right_drive,
    output logic signed [31:0]                  o_left_drive,
    output logic                                o_drive_valid,
    output logic                                o_clear_markers,
    output logic [1:0]                          o_state_now
);

    localparam int MODE_LAST = ((MODE_COUNT < ltdc_pkg::NUM_TARGETS) ?
                                MODE_COUNT : ltdc_pkg::NUM_TARGETS) - 1;
    localparam logic [ltdc_pkg::TREAD_W-1:0] TREAD = ltdc_pkg::TREAD_W'(HALF_TREAD);

    logic [15:0] r_target [ltdc_pkg::NUM_TARGETS];
    logic [1:0]  r_mode;
    logic [15:0] r_full_scale;
    logic [15:0] r_stop_delay;
    logic [7:0]  r_goal_limit;

    logic               r_func;
    logic signed [15:0] r_offset;
    logic [7:0]         r_markers;
    logic [15:0]        r_battery;
    logic [1:0]         r_new_state;

    logic [31:0]        r_quo;
    logic [15:0]        r_rem;
    logic signed [25:0] r_turn;

    logic [1:0]  r_drv_state, n_drv_state;
    logic [15:0] r_countdown, n_countdown;

    logic               r_valid;
    logic signed [31:0] r_right, n_right;
    logic signed [31:0] r_left, n_left;
    logic               r_drive_valid, n_drive_valid;
    logic               r_clear, n_clear;

    logic [1:0]         w_sel;
    logic [31:0]        w_prod;
    logic signed [16:0] w_neg_off;
    logic signed [25:0] w_turn;
    logic [16:0]        w_trial;
    logic               w_fit;
    logic signed [31:0] w_duty;
    logic signed [33:0] w_sum_r;
    logic signed [33:0] w_sum_l;
    logic               w_out_free;

    assign w_sel = ({30'd0, r_mode} > MODE_LAST) ? 2'(MODE_LAST) : r_mode;

    assign w_prod    = 32'(r_full_scale) * 32'(r_target[w_sel]);
    assign w_neg_off = -$signed({r_offset[15], r_offset});
    assign w_turn    = w_neg_off * $signed({1'b0, TREAD});

    assign w_trial = {r_rem, r_quo[31]};
    assign w_fit   = (w_trial >= {1'b0, r_battery});

    assign w_duty  = r_quo[31] ? ltdc_pkg::S32_MAX : $signed(r_quo);
    assign w_sum_r = 34'(w_duty) + 34'(r_turn);
    assign w_sum_l = 34'(w_duty) - 34'(r_turn);

    assign w_out_free = !r_valid || !i_stall;
    assign o_status.func     = r_func;
    assign o_status.out_free = w_out_free;

    always_comb begin
        n_drv_state   = r_drv_state;
        n_countdown   = r_countdown;
        n_right       = '0;
        n_left        = '0;
        n_drive_valid = 1'b0;
        n_clear       = 1'b0;
        if (r_func) begin
            n_drv_state = r_new_state;
        end else begin
            case (r_drv_state)
                ltdc_pkg::ST_TO_RUN: begin
                    n_clear     = 1'b1;
                    n_drv_state = ltdc_pkg::ST_RUN;
                end
                ltdc_pkg::ST_RUN: begin
                    n_drive_valid = 1'b1;
                    n_right       = ltdc_pkg::sat32(w_sum_r);
                    n_left        = ltdc_pkg::sat32(w_sum_l);
                    if (r_markers >= r_goal_limit) begin
                        n_drv_state = ltdc_pkg::ST_TO_STOP;
                        n_countdown = r_stop_delay;
                    end
                end
                ltdc_pkg::ST_TO_STOP: begin
                    n_drive_valid = 1'b1;
                    n_right       = ltdc_pkg::sat32(w_sum_r);
                    n_left        = ltdc_pkg::sat32(w_sum_l);
                    if (r_countdown == '0) begin
                        n_drv_state = ltdc_pkg::ST_STOP;
                    end
                end
                default: begin
                    n_drive_valid = 1'b1;
                    n_right       = 32'sd1;
                    n_left        = 32'sd1;
                end
            endcase
            if (n_countdown != '0) begin
                n_countdown = n_countdown - 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ltdc_pkg::NUM_TARGETS; k++) begin
                r_target[k] <= '0;
            end
            r_mode       <= '0;
            r_full_scale <= ltdc_pkg::FULL_SCALE_RST;
            r_stop_delay <= ltdc_pkg::STOP_DELAY_RST;
            r_goal_limit <= ltdc_pkg::GOAL_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ltdc_pkg::REG_TARGET0:    r_target[0]  <= i_cfg_data;
                ltdc_pkg::REG_TARGET1:    r_target[1]  <= i_cfg_data;
                ltdc_pkg::REG_TARGET2:    r_target[2]  <= i_cfg_data;
                ltdc_pkg::REG_TARGET3:    r_target[3]  <= i_cfg_data;
                ltdc_pkg::REG_MODE:       r_mode       <= i_cfg_data[1:0];
                ltdc_pkg::REG_FULL_SCALE: r_full_scale <= i_cfg_data;
                ltdc_pkg::REG_STOP_DELAY: r_stop_delay <= i_cfg_data;
                ltdc_pkg::REG_GOAL_LIMIT: r_goal_limit <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func      <= i_func;
            r_offset    <= i_line_offset;
            r_markers   <= i_marker_count;
            r_battery   <= i_battery_mv;
            r_new_state <= i_new_state;
        end
        if (i_cmd.mul) begin
            r_quo  <= w_prod;
            r_rem  <= '0;
            r_turn <= w_turn;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[30:0], w_fit};
            r_rem <= w_fit ? 16'(w_trial - {1'b0, r_battery}) : w_trial[15:0];
        end
        if (i_cmd.commit) begin
            r_right       <= n_right;
            r_left        <= n_left;
            r_drive_valid <= n_drive_valid;
            r_clear       <= n_clear;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drv_state <= ltdc_pkg::ST_STOP;
            r_countdown <= '0;
            r_valid     <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_drv_state <= n_drv_state;
                r_countdown <= n_countdown;
                r_valid     <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid         = r_valid;
    assign o_right_drive   = r_right;
    assign o_left_drive    = r_left;
    assign o_drive_valid   = r_drive_valid;
    assign o_clear_markers = r_clear;
    assign o_state_now     = r_drv_state;

    a_no_drive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_drive_valid) |-> (r_right == '0 && r_left == '0))
        else $error("drive values present without drive");

    a_clear_to_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_clear) |-> (r_drv_state == ltdc_pkg::ST_RUN && !r_drive_valid))
        else $error("marker clear outside run entry");

    a_countdown_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.commit |=> $stable(r_countdown))
        else $error("countdown changed without commit");

endmodule

`default_nettype wire

@@ rtl/line_tracer_drive_control_core.sv @@
// ----------------------------------------------------------------------------
// line_tracer_drive_control_core
// Four-state line tracer drive controller with battery-compensated duty.
//
//  channel  direction  handshake            payload
//  input    in         i_valid / o_stall    i_func, i_line_offset,
//                                           i_marker_count, i_battery_mv,
//                                           i_new_state
//  result   out        o_valid / i_stall    o_right_drive, o_left_drive,
//                                           o_drive_valid, o_clear_markers,
//                                           o_state_now
//  config   in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// A control tick is captured, then goes through the duty multiply, the radix-2
// divider and a final step that forms the drive. A set-state item skips the
// divider. One item is in flight at a time.
// Reset is synchronous, active low; no clearing pass is needed.
// The result register holds while i_stall is high; the next item may be
// accepted and worked on meanwhile, and commits once the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module line_tracer_drive_control_core #(
    parameter int MODE_COUNT = ltdc_pkg::MODE_COUNT_DEF,
    parameter int HALF_TREAD = ltdc_pkg::HALF_TREAD_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire  [ltdc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [ltdc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire                             i_valid,
    output logic                            o_stall,
    input  wire                             i_func,
    input  wire  signed [15:0]              i_line_offset,
    input  wire  [7:0]                      i_marker_count,
    input  wire  [15:0]                     i_battery_mv,
    input  wire  [1:0]                      i_new_state,
    output logic                            o_valid,
    input  wire                             i_stall,
    output logic signed [31:0]              o_right_drive,
    output logic signed [31:0]              o_left_drive,
    output logic                            o_drive_valid,
    output logic                            o_clear_markers,
    output logic [1:0]                      o_state_now
);

    ltdc_pkg::t_dp_cmd    w_cmd;
    ltdc_pkg::t_dp_status w_status;

    ltdc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    ltdc_dp #(
        .MODE_COUNT (MODE_COUNT),
        .HALF_TREAD (HALF_TREAD)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_func          (i_func),
        .i_line_offset   (i_line_offset),
        .i_marker_count  (i_marker_count),
        .i_battery_mv    (i_battery_mv),
        .i_new_state     (i_new_state),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_right_drive   (o_right_drive),
        .o_left_drive    (o_left_drive),
        .o_drive_valid   (o_drive_valid),
        .o_clear_markers (o_clear_markers),
        .o_state_now     (o_state_now)
    );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives line_tracer_drive_control_core with control ticks and set-state
// items and checks every result against an in-bench model of the controller
// state, the stop countdown and the battery-compensated duty. Directed items
// cover the states, the duty and drive limits and the goal stop. Random
// phases follow, each with new register values and its own sender and
// receiver gap pattern.
// ----------------------------------------------------------------------------
module testbench;
    import ltdc_pkg::*;

    localparam logic FUNC_TICK      = 1'b0;
    localparam logic FUNC_SET_STATE = 1'b1;
    localparam int   IDLE_LIMIT     = 2000;
    localparam int   DRAIN_CYCLES   = 40;
    localparam int   PHASES         = 10;
    localparam int   PHASE_ITEMS    = 155;

    typedef struct {
        logic               func;
        logic signed [15:0] line_offset;
        logic [7:0]         marker_count;
        logic [15:0]        battery_mv;
        logic [1:0]         new_state;
    } ctrl_item_t;

    typedef struct {
        logic signed [31:0] right_drive;
        logic signed [31:0] left_drive;
        logic               drive_valid;
        logic               clear_markers;
        logic [1:0]         state_now;
    } drive_cmd_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_func;
    logic signed [15:0]    i_line_offset;
    logic [7:0]            i_marker_count;
    logic [15:0]           i_battery_mv;
    logic [1:0]            i_new_state;
    logic                  o_valid;
    logic                  i_stall;
    logic signed [31:0]    o_right_drive;
    logic signed [31:0]    o_left_drive;
    logic                  o_drive_valid;
    logic                  o_clear_markers;
    logic [1:0]            o_state_now;

    logic [15:0] target_mv_q [NUM_TARGETS];
    logic [1:0]  sel_mode;
    logic [15:0] full_scale;
    logic [15:0] stop_delay;
    logic [7:0]  goal_limit;
    logic [1:0]  ctrl_state;
    logic [15:0] stop_countdown;

    drive_cmd_t expected_cmds [$];
    int         errors;
    int         snd_max_gap;
    int         rcv_max_stall;
    int         stall_left;

    line_tracer_drive_control_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_func          (i_func),
        .i_line_offset   (i_line_offset),
        .i_marker_count  (i_marker_count),
        .i_battery_mv    (i_battery_mv),
        .i_new_state     (i_new_state),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_right_drive   (o_right_drive),
        .o_left_drive    (o_left_drive),
        .o_drive_valid   (o_drive_valid),
        .o_clear_markers (o_clear_markers),
        .o_state_now     (o_state_now)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic signed [31:0] clamp_s32(input longint v);
        if (v > longint'(S32_MAX)) return S32_MAX;
        if (v < longint'(S32_MIN)) return S32_MIN;
        return v[31:0];
    endfunction

    function automatic longint straight_duty(input logic [15:0] battery);
        logic [31:0] product;
        logic [31:0] quotient;
        if (battery == 16'd0) return longint'(S32_MAX);
        product  = 32'(full_scale) * 32'(target_mv_q[sel_mode]);
        quotient = product / 32'(battery);
        if (quotient > 32'h7FFF_FFFF) return longint'(S32_MAX);
        return {32'd0, quotient};
    endfunction

    function automatic drive_cmd_t predict_drive(input ctrl_item_t it);
        drive_cmd_t r;
        longint     duty;
        longint     turn;
        r.right_drive   = '0;
        r.left_drive    = '0;
        r.drive_valid   = 1'b0;
        r.clear_markers = 1'b0;
        if (it.func == FUNC_SET_STATE) begin
            ctrl_state = it.new_state;
        end else begin
            duty = straight_duty(it.battery_mv);
            turn = longint'(HALF_TREAD_DEF) * -longint'(it.line_offset);
            case (ctrl_state)
                ST_TO_RUN: begin
                    r.clear_markers = 1'b1;
                    ctrl_state      = ST_RUN;
                end
                ST_RUN, ST_TO_STOP: begin
                    r.drive_valid = 1'b1;
                    r.right_drive = clamp_s32(duty + turn);
                    r.left_drive  = clamp_s32(duty - turn);
                    if (ctrl_state == ST_RUN) begin
                        if (it.marker_count >= goal_limit) begin
                            ctrl_state     = ST_TO_STOP;
                            stop_countdown = stop_delay;
                        end
                    end else if (stop_countdown == 16'd0) begin
                        ctrl_state = ST_STOP;
                    end
                end
                default: begin
                    r.drive_valid = 1'b1;
                    r.right_drive = 32'sd1;
                    r.left_drive  = 32'sd1;
                end
            endcase
            if (stop_countdown != 16'd0) stop_countdown = stop_countdown - 16'd1;
        end
        r.state_now = ctrl_state;
        return r;
    endfunction

    function automatic ctrl_item_t tick_item(input logic signed [15:0] offset,
                                             input logic [7:0] markers,
                                             input logic [15:0] battery);
        ctrl_item_t it;
        it.func         = FUNC_TICK;
        it.line_offset  = offset;
        it.marker_count = markers;
        it.battery_mv   = battery;
        it.new_state    = 2'($urandom);
        return it;
    endfunction

    function automatic ctrl_item_t state_item(input logic [1:0] st);
        ctrl_item_t it;
        it.func         = FUNC_SET_STATE;
        it.line_offset  = 16'($urandom);
        it.marker_count = 8'($urandom);
        it.battery_mv   = 16'($urandom);
        it.new_state    = st;
        return it;
    endfunction

    task automatic report_error(input string what);
        $display("error at %0t: %s", $realtime, what);
        errors++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_MODE:       sel_mode   = data[1:0];
            REG_FULL_SCALE: full_scale = data;
            REG_STOP_DELAY: stop_delay = data;
            REG_GOAL_LIMIT: goal_limit = data[7:0];
            default:        target_mv_q[idx[1:0]] = data;
        endcase
    endtask

    // drop valid and hold until every pending result is out
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (expected_cmds.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic send_item(input ctrl_item_t it);
        int gap;
        gap = $urandom_range(0, snd_max_gap);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_func         = it.func;
        i_line_offset  = it.line_offset;
        i_marker_count = it.marker_count;
        i_battery_mv   = it.battery_mv;
        i_new_state    = it.new_state;
        i_valid        = 1'b1;
        do @(posedge i_clk); while (o_stall);
        expected_cmds.push_back(predict_drive(it));
    endtask

    always @(posedge i_clk) begin : result_check
        drive_cmd_t want;
        if (i_rst_n && o_valid) begin
            if (i_stall) begin
                if (stall_left > 0) stall_left--;
            end else begin
                if (expected_cmds.size() == 0) begin
                    report_error("result with no item pending");
                end else begin
                    want = expected_cmds.pop_front();
                    if (o_right_drive !== want.right_drive)
                        report_error($sformatf("right_drive %0d, expected %0d",
                                               o_right_drive, want.right_drive));
                    if (o_left_drive !== want.left_drive)
                        report_error($sformatf("left_drive %0d, expected %0d",
                                               o_left_drive, want.left_drive));
                    if (o_drive_valid !== want.drive_valid)
                        report_error($sformatf("drive_valid %b, expected %b",
                                               o_drive_valid, want.drive_valid));
                    if (o_clear_markers !== want.clear_markers)
                        report_error($sformatf("clear_markers %b, expected %b",
                                               o_clear_markers, want.clear_markers));
                    if (o_state_now !== want.state_now)
                        report_error($sformatf("state_now %0d, expected %0d",
                                               o_state_now, want.state_now));
                end
                stall_left = $urandom_range(0, rcv_max_stall);
            end
        end
    end

    always @(negedge i_clk) i_stall = (stall_left != 0);

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle = 0;
            else idle++;
        end
        $display("status: fail");
        $finish;
    end

    task automatic test_stop_drive();
        send_item(tick_item(-16'sd32768, 8'd0, 16'd0));
        send_item(tick_item(16'sd32767, 8'd255, 16'hFFFF));
    endtask

    task automatic test_set_state();
        send_item(state_item(ST_TO_RUN));
        send_item(tick_item(16'sd0, 8'd0, 16'd5000));
        send_item(tick_item(16'sd100, 8'd1, 16'd5000));
        send_item(state_item(ST_TO_STOP));
        send_item(tick_item(-16'sd250, 8'd0, 16'd4000));
        send_item(state_item(ST_RUN));
        send_item(state_item(ST_STOP));
    endtask

    task automatic test_duty_limits();
        wait_idle();
        write_reg(REG_TARGET0, 16'hFFFF);
        write_reg(REG_TARGET1, 16'd0);
        write_reg(REG_TARGET2, 16'd1234);
        write_reg(REG_TARGET3, 16'hFFFF);
        write_reg(REG_FULL_SCALE, 16'hFFFF);
        write_reg(REG_GOAL_LIMIT, 16'd255);
        send_item(state_item(ST_RUN));
        send_item(tick_item(16'sd0, 8'd0, 16'd0));
        send_item(tick_item(16'sd32767, 8'd0, 16'd1));
        send_item(tick_item(-16'sd32768, 8'd0, 16'd1));
        send_item(tick_item(16'sd0, 8'd0, 16'hFFFF));
        wait_idle();
        write_reg(REG_MODE, 16'd1);
        send_item(tick_item(16'sd32767, 8'd0, 16'd300));
        wait_idle();
        write_reg(REG_MODE, 16'd3);
        write_reg(REG_FULL_SCALE, 16'd0);
        send_item(tick_item(-16'sd32768, 8'd254, 16'hFFFF));
        wait_idle();
        write_reg(REG_MODE, 16'd2);
        write_reg(REG_FULL_SCALE, 16'd1000);
        send_item(tick_item(16'sd5, 8'd255, 16'd7));
    endtask

    task automatic test_goal_stop();
        wait_idle();
        write_reg(REG_GOAL_LIMIT, 16'd1);
        write_reg(REG_STOP_DELAY, 16'd0);
        send_item(state_item(ST_RUN));
        send_item(tick_item(16'sd12, 8'd1, 16'd3000));
        send_item(tick_item(-16'sd12, 8'd0, 16'd3000));
        wait_idle();
        write_reg(REG_STOP_DELAY, 16'd2);
        send_item(state_item(ST_RUN));
        send_item(tick_item(16'sd1, 8'd0, 16'd7400));
        send_item(tick_item(16'sd2, 8'd9, 16'd7400));
        send_item(tick_item(16'sd3, 8'd0, 16'd7400));
        send_item(tick_item(16'sd4, 8'd0, 16'd7400));
    endtask

    function automatic logic [15:0] pick_edge(input logic [15:0] hi);
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return hi;
            default: return 16'($urandom_range(0, hi));
        endcase
    endfunction

    function automatic logic signed [15:0] rand_offset();
        case ($urandom_range(0, 7))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2:       return 16'($urandom_range(0, 200)) - 16'd100;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] rand_markers();
        case ($urandom_range(0, 7))
            0:       return 8'($urandom);
            1:       return goal_limit;
            default: return 8'($urandom_range(0, goal_limit - 1));
        endcase
    endfunction

    function automatic logic [15:0] rand_battery();
        int roll;
        roll = $urandom_range(0, 15);
        if (roll == 0) return 16'd0;
        if (roll < 4) return 16'($urandom_range(1, 16));
        return 16'($urandom);
    endfunction

    task automatic test_random_phases();
        int phase;
        int n;
        int roll;
        for (phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            snd_max_gap   = phase[0] ? 0 : 10;
            rcv_max_stall = phase[1] ? 0 : 10;
            if (phase == 0) begin
                for (n = 0; n < NUM_TARGETS; n++) write_reg(REG_TARGET0 + 3'(n), 16'd0);
                write_reg(REG_MODE, 16'd0);
                write_reg(REG_FULL_SCALE, 16'd1);
                write_reg(REG_STOP_DELAY, 16'd0);
                write_reg(REG_GOAL_LIMIT, 16'd1);
            end else if (phase == 1) begin
                for (n = 0; n < NUM_TARGETS; n++) write_reg(REG_TARGET0 + 3'(n), 16'hFFFF);
                write_reg(REG_MODE, 16'd3);
                write_reg(REG_FULL_SCALE, 16'hFFFF);
                write_reg(REG_STOP_DELAY, 16'hFFFF);
                write_reg(REG_GOAL_LIMIT, 16'd255);
            end else begin
                for (n = 0; n < NUM_TARGETS; n++)
                    write_reg(REG_TARGET0 + 3'(n), pick_edge(16'hFFFF));
                write_reg(REG_MODE, 16'($urandom_range(0, 3)));
                write_reg(REG_FULL_SCALE, 16'($urandom_range(1, 65535)));
                write_reg(REG_STOP_DELAY, 16'($urandom_range(0, 24)));
                write_reg(REG_GOAL_LIMIT, 16'($urandom_range(1, 8)));
            end
            for (n = 0; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(0, 15);
                if (roll == 0)
                    send_item(state_item(2'($urandom)));
                else if (ctrl_state == ST_STOP && roll < 8)
                    send_item(state_item(ST_TO_RUN));
                else
                    send_item(tick_item(rand_offset(), rand_markers(), rand_battery()));
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_func         = FUNC_TICK;
        i_line_offset  = '0;
        i_marker_count = '0;
        i_battery_mv   = '0;
        i_new_state    = ST_STOP;
        i_stall        = 1'b0;
        errors         = 0;
        stall_left     = 0;
        snd_max_gap    = 10;
        rcv_max_stall  = 10;
        for (int m = 0; m < NUM_TARGETS; m++) target_mv_q[m] = 16'd0;
        sel_mode       = 2'd0;
        full_scale     = FULL_SCALE_RST;
        stop_delay     = STOP_DELAY_RST;
        goal_limit     = GOAL_LIMIT_RST;
        ctrl_state     = ST_STOP;
        stop_countdown = 16'd0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_stop_drive();
        test_set_state();
        test_duty_limits();
        test_goal_stop();
        test_random_phases();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_cmds.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
